// ===== src/wpm_pkg.sv =====
// shared constants, types and helpers for the wildcard pattern matcher
package wpm_pkg;

  // storage capacities
  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned TEXT_MAX    = 256;

  localparam int unsigned PAT_AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned TEXT_AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int unsigned PLEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned TLEN_W  = $clog2(TEXT_MAX + 1);

  // command codes
  localparam logic [1:0] CMD_PAT_CHAR  = 2'd0;
  localparam logic [1:0] CMD_TEXT_CHAR = 2'd1;
  localparam logic [1:0] CMD_EVAL      = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  // match mode codes
  localparam logic [1:0] MODE_LIKE_CS = 2'd0;
  localparam logic [1:0] MODE_LIKE_CI = 2'd1;
  localparam logic [1:0] MODE_GLOB_CI = 2'd2;

  // wildcard characters
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic step;       // one comparison step on the read data
    logic tail_step;  // skip one trailing any-run wildcard
    logic out_load;   // load the result register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ovf;         // pattern or text overflowed
    logic text_empty;  // no text characters in the row
    logic step_fail;   // comparison step found a mismatch with no backtrack point
    logic step_end;    // comparison step consumed the last text character
    logic tail_end;    // pattern pointer reached the pattern length
    logic tail_run;    // pattern character at the pointer is an any-run wildcard
    logic out_free;    // result register can take a new result
  } dp_sts_t;

  // ascii upper case to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== src/wpm_ram.sv =====
// generic single write port ram with registered read
module wpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wpm_dp.sv =====
// datapath: pattern and text stores, match pointers, result register
module wpm_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wpm_pkg::dp_cmd_t cmd_i,
  input  logic [1:0]       command_i,
  input  logic [7:0]       char_byte_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             out_stall_i,
  output wpm_pkg::dp_sts_t sts_o,
  output logic             out_valid_o,
  output logic             matched_o,
  output logic             overflow_o
);
  import wpm_pkg::*;

  logic [1:0]        mode_q;
  logic [PLEN_W-1:0] plen_q;
  logic              povf_q;
  logic [TLEN_W-1:0] tlen_q;
  logic              tovf_q;
  logic [TLEN_W-1:0] ti_q, ti_d, bti_q, bti_d;
  logic [PLEN_W-1:0] pi_q, pi_d, bpi_q, bpi_d;
  logic              have_q, have_d;
  logic              fail_q, fail_d;
  logic              out_valid_q, matched_q, overflow_q;

  logic       pat_we, text_we;
  logic [7:0] pat_rdata, text_rdata;
  logic       glob, fold, same, p_in;
  logic [7:0] any_run, any_one, tc, pc;

  // store write enables
  assign pat_we  = cmd_i.accept && (command_i == CMD_PAT_CHAR) &&
                   (plen_q < PLEN_W'(PATTERN_MAX));
  assign text_we = cmd_i.accept && (command_i == CMD_TEXT_CHAR) &&
                   (tlen_q < TLEN_W'(TEXT_MAX));

  wpm_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (plen_q[PAT_AW-1:0]),
    .wdata_i (char_byte_i),
    .raddr_i (pi_q[PAT_AW-1:0]),
    .rdata_o (pat_rdata)
  );

  wpm_ram #(.WIDTH(8), .DEPTH(TEXT_MAX)) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (tlen_q[TEXT_AW-1:0]),
    .wdata_i (char_byte_i),
    .raddr_i (ti_q[TEXT_AW-1:0]),
    .rdata_o (text_rdata)
  );

  // mode decode
  assign glob    = mode_q[1];
  assign fold    = (mode_q != MODE_LIKE_CS);
  assign any_run = glob ? CH_STAR : CH_PERCENT;
  assign any_one = glob ? CH_QUESTION : CH_UNDER;
  assign tc      = text_rdata;
  assign pc      = pat_rdata;
  assign p_in    = (pi_q < plen_q);
  assign same    = fold ? (fold_case(tc) == fold_case(pc)) : (tc == pc);

  // pointer reset on end of row, and pointer update for one comparison step or tail skip
  always_comb begin
    ti_d   = ti_q;
    pi_d   = pi_q;
    bti_d  = bti_q;
    bpi_d  = bpi_q;
    have_d = have_q;
    fail_d = fail_q;
    if (cmd_i.accept && command_i == CMD_EVAL) begin
      ti_d   = '0;
      pi_d   = '0;
      bti_d  = '0;
      bpi_d  = '0;
      have_d = 1'b0;
      fail_d = 1'b0;
    end else if (cmd_i.step) begin
      if (p_in && pc == any_run) begin
        bpi_d  = pi_q;
        bti_d  = ti_q;
        have_d = 1'b1;
        pi_d   = pi_q + 1'b1;
      end else if (p_in && (pc == any_one || same)) begin
        ti_d = ti_q + 1'b1;
        pi_d = pi_q + 1'b1;
      end else if (have_q) begin
        pi_d  = bpi_q + 1'b1;
        bti_d = bti_q + 1'b1;
        ti_d  = bti_q + 1'b1;
      end else begin
        fail_d = 1'b1;
      end
    end else if (cmd_i.tail_step) begin
      if (pc == any_run) begin
        pi_d = pi_q + 1'b1;
      end
    end
  end

  // status to the controller
  assign sts_o.ovf        = povf_q || tovf_q;
  assign sts_o.text_empty = (tlen_q == '0);
  assign sts_o.step_fail  = fail_d;
  assign sts_o.step_end   = (ti_d >= tlen_q);
  assign sts_o.tail_end   = (pi_q >= plen_q);
  assign sts_o.tail_run   = (pc == any_run);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LIKE_CS;
      plen_q      <= '0;
      povf_q      <= 1'b0;
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      ti_q        <= '0;
      pi_q        <= '0;
      bti_q       <= '0;
      bpi_q       <= '0;
      have_q      <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      ti_q   <= ti_d;
      pi_q   <= pi_d;
      bti_q  <= bti_d;
      bpi_q  <= bpi_d;
      have_q <= have_d;
      fail_q <= fail_d;
      // pattern and text loading
      if (cmd_i.accept) begin
        case (command_i)
          CMD_PAT_CHAR: begin
            if (pat_we) plen_q <= plen_q + 1'b1;
            else        povf_q <= 1'b1;
          end
          CMD_TEXT_CHAR: begin
            if (text_we) tlen_q <= tlen_q + 1'b1;
            else         tovf_q <= 1'b1;
          end
          CMD_CLEAR: begin
            plen_q <= '0;
            povf_q <= 1'b0;
          end
          default: ;
        endcase
      end
      // row is finished once its result is loaded
      if (cmd_i.out_load) begin
        tlen_q <= '0;
        tovf_q <= 1'b0;
      end
      // output register
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      overflow_q <= povf_q || tovf_q;
      matched_q  <= !(povf_q || tovf_q) && !fail_q && (pi_q == plen_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

endmodule

// ===== src/wpm_ctrl.sv =====
// controller: sequences loading, the match walk and result delivery
module wpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       command_i,
  input  wpm_pkg::dp_sts_t sts_i,
  output logic             in_stall_o,
  output logic             idle_o,
  output wpm_pkg::dp_cmd_t cmd_o
);
  import wpm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;  // read text and pattern at the pointers
  localparam logic [2:0] S_MCMP = 3'd2;  // compare and move the pointers
  localparam logic [2:0] S_TRD  = 3'd3;  // read pattern for trailing wildcards
  localparam logic [2:0] S_TCMP = 3'd4;  // skip one trailing wildcard
  localparam logic [2:0] S_DONE = 3'd5;  // wait for the result register

  logic [2:0] state_q, state_d;
  logic       accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign idle_o     = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && command_i == CMD_EVAL) begin
          if (sts_i.ovf)             state_d = S_DONE;
          else if (sts_i.text_empty) state_d = S_TRD;
          else                       state_d = S_MRD;
        end
      end
      S_MRD: begin
        state_d = S_MCMP;
      end
      S_MCMP: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_fail)     state_d = S_DONE;
        else if (sts_i.step_end) state_d = S_TRD;
        else                     state_d = S_MRD;
      end
      S_TRD: begin
        if (sts_i.tail_end) state_d = S_DONE;
        else                state_d = S_TCMP;
      end
      S_TCMP: begin
        cmd_o.tail_step = 1'b1;
        if (sts_i.tail_run) state_d = S_TRD;
        else                state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/wildcard_pattern_matcher_unit.sv =====
// top level of the wildcard pattern matcher: controller plus datapath
//
//  channel  signals                                   direction
//  input    in_valid_i, in_stall_o, command_i,        in
//           char_byte_i
//  output   out_valid_o, out_stall_i, matched_o,      out
//           overflow_o
//  config   cfg_we_i, cfg_wdata_i (match mode)        in
//
// a character or clear command leaves the block ready and the next transfer can follow at once
// end of row walks the text with comparison steps, then checks the trailing
// pattern characters until the pattern end is reached, then loads the result;
// an overflowed row goes straight to the result; every step waits on the registered
// read of the pattern and text rams, and backtracking repeats steps
// reset is asynchronous active low; no clearing pass, the stores need none
// a waiting result does not block character transfers; a new result waits
// until the output register frees
module wildcard_pattern_matcher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       overflow_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);
  import wpm_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    ctrl_idle;

  wpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .sts_i      (dp_sts),
    .in_stall_o (in_stall_o),
    .idle_o     (ctrl_idle),
    .cmd_o      (dp_cmd)
  );

  wpm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .command_i   (command_i),
    .char_byte_i (char_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .matched_o   (matched_o),
    .overflow_o  (overflow_o)
  );

  // an overflowed row never reports a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !matched_o)
    else $error("overflowed row reported a match");

  // a character or clear transfer leaves the block ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i != CMD_EVAL |=> !in_stall_o)
    else $error("block stalled after a non-evaluating transfer");

  // an end of row transfer starts an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CMD_EVAL |=> !ctrl_idle)
    else $error("end of row did not start an evaluation");

  // a new result appears only at the end of an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ctrl_idle && $past(in_stall_o))
    else $error("result produced outside an evaluation");

endmodule

// ===== bench/match_checker.sv =====
// checker for the wildcard pattern matcher: predicts each verdict and compares the result channel
module match_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] command_i,
  input  logic [7:0] char_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       matched_i,
  input  logic       overflow_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_o,
  output int         hits_o,
  output int         flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // verdicts still owed by the block, oldest first
  verdict_t   owed_verdicts[$];
  verdict_t   got;
  verdict_t   want;

  // shadow of the block's state
  logic [1:0] mode;
  logic [7:0] pat_mem [PATTERN_MAX];
  int         pat_len;
  logic       pat_ovf;
  logic [7:0] row_mem [TEXT_MAX];
  int         row_len;
  logic       row_ovf;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // greedy scan with a single backtrack point at the last any-run wildcard
  function automatic logic row_matches();
    logic [7:0] run_ch;
    logic [7:0] one_ch;
    logic [7:0] tc;
    logic [7:0] pc;
    logic       fold;
    logic       same;
    logic       have_back;
    int         ti;
    int         pi;
    int         back_pi;
    int         back_ti;
    run_ch = mode[1] ? CH_STAR : CH_PERCENT;
    one_ch = mode[1] ? CH_QUESTION : CH_UNDER;
    fold = (mode != MODE_LIKE_CS);
    ti = 0;
    pi = 0;
    back_pi = 0;
    back_ti = 0;
    have_back = 1'b0;
    while (ti < row_len) begin
      tc = row_mem[ti];
      pc = (pi < pat_len) ? pat_mem[pi] : 8'h00;
      same = fold ? (to_lower(tc) == to_lower(pc)) : (tc == pc);
      if (pi < pat_len && pc == run_ch) begin
        back_pi = pi;
        back_ti = ti;
        have_back = 1'b1;
        pi++;
      end else if (pi < pat_len && (pc == one_ch || same)) begin
        ti++;
        pi++;
      end else if (have_back) begin
        pi = back_pi + 1;
        back_ti++;
        ti = back_ti;
      end else begin
        return 1'b0;
      end
    end
    // trailing any-run wildcards match the empty rest
    while (pi < pat_len && pat_mem[pi] == run_ch) pi++;
    return pi == pat_len;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = MODE_LIKE_CS;
      pat_len = 0;
      pat_ovf = 1'b0;
      row_len = 0;
      row_ovf = 1'b0;
      owed_verdicts.delete();
      fail_count_o = 0;
      pending_o = 0;
      results_o = 0;
      hits_o = 0;
      flagged_o = 0;
    end else begin
      // result transfer: retire the oldest verdict before any new one is queued
      if (out_valid_i && !out_stall_i) begin
        got.matched = matched_i;
        got.overflow = overflow_i;
        results_o++;
        if (got.matched) hits_o++;
        if (got.overflow) flagged_o++;
        if (owed_verdicts.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual matched=%0b overflow=%0b",
                   $time, got.matched, got.overflow);
          fail_count_o++;
        end else begin
          want = owed_verdicts.pop_front();
          if (got.matched !== want.matched) begin
            $display("%0t ns: matched wrong, expected %0b actual %0b",
                     $time, want.matched, got.matched);
            fail_count_o++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t ns: overflow wrong, expected %0b actual %0b",
                     $time, want.overflow, got.overflow);
            fail_count_o++;
          end
        end
      end

      // mode register write
      if (cfg_we_i) mode = cfg_wdata_i;

      // input transfer
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_PAT_CHAR: begin
            if (pat_len < PATTERN_MAX) begin
              pat_mem[pat_len] = char_byte_i;
              pat_len++;
            end else begin
              pat_ovf = 1'b1;
            end
          end
          CMD_TEXT_CHAR: begin
            if (row_len < TEXT_MAX) begin
              row_mem[row_len] = char_byte_i;
              row_len++;
            end else begin
              row_ovf = 1'b1;
            end
          end
          CMD_EVAL: begin
            want.overflow = pat_ovf || row_ovf;
            want.matched = want.overflow ? 1'b0 : row_matches();
            owed_verdicts = {owed_verdicts, want};
            row_len = 0;
            row_ovf = 1'b0;
          end
          default: begin
            pat_len = 0;
            pat_ovf = 1'b0;
          end
        endcase
      end
      pending_o = owed_verdicts.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the wildcard pattern matcher: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 160;
  localparam int QUIET_TAIL   = 40;

  // mode code with no meaning of its own, behaves as glob
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] command_i;
  logic [7:0] char_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       matched_o;
  logic       overflow_o;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  int         fail_count;
  int         pending;
  int         results;
  int         hits;
  int         flagged;

  int         items_sent = 0;
  int         cycles = 0;
  bit         idle_on = 1'b1;
  int         gap_pct = 20;
  int         stall_pct = 30;
  logic [1:0] cur_mode = MODE_LIKE_CS;
  logic [7:0] pat_q[$];

  wildcard_pattern_matcher_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .char_byte_i (char_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .matched_o   (matched_o),
    .overflow_o  (overflow_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  match_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .command_i    (command_i),
    .char_byte_i  (char_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .matched_i    (matched_o),
    .overflow_i   (overflow_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .hits_o       (hits),
    .flagged_o    (flagged)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!idle_on) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
        repeat ($urandom_range(0, 12)) if (idle_on) @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] run_char(input logic [1:0] m);
    return m[1] ? CH_STAR : CH_PERCENT;
  endfunction

  function automatic logic [7:0] one_char(input logic [1:0] m);
    return m[1] ? CH_QUESTION : CH_UNDER;
  endfunction

  // small alphabet so that rows match often, plus wildcards and arbitrary bytes
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = $urandom_range(0, 1) ? "b" : "a";
      3:       c = $urandom_range(0, 1) ? "B" : "A";
      4:       c = run_char(cur_mode);
      5:       c = one_char(cur_mode);
      6: begin
        case ($urandom_range(0, 3))
          0:       c = CH_PERCENT;
          1:       c = CH_UNDER;
          2:       c = CH_STAR;
          default: c = CH_QUESTION;
        endcase
      end
      7: begin
        // bytes just around the folded letter ranges
        case ($urandom_range(0, 5))
          0:       c = 8'h40;
          1:       c = 8'h5A;
          2:       c = 8'h5B;
          3:       c = 8'h60;
          4:       c = 8'h7A;
          default: c = 8'h7B;
        endcase
      end
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    char_byte_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (cmd == CMD_CLEAR) pat_q.delete();
    else if (cmd == CMD_PAT_CHAR) pat_q = {pat_q, ch};
  endtask

  // hold off until every owed verdict is back and the block has settled
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_all_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_str(input logic [1:0] cmd, input string s);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i]);
  endtask

  task automatic new_pattern(input string s);
    send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
    send_str(CMD_PAT_CHAR, s);
  endtask

  task automatic eval_row(input string s);
    send_str(CMD_TEXT_CHAR, s);
    send_item(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_pattern(input int len);
    send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
    repeat (len) send_item(CMD_PAT_CHAR, pick_char());
  endtask

  task automatic send_random_row(input int len);
    repeat (len) send_item(CMD_TEXT_CHAR, pick_char());
    send_item(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  // row built from the current pattern so it usually matches; sometimes one char too many
  task automatic send_derived_row();
    logic [7:0] c;
    foreach (pat_q[i]) begin
      c = pat_q[i];
      if (c == run_char(cur_mode)) begin
        repeat ($urandom_range(0, 3)) send_item(CMD_TEXT_CHAR, pick_char());
      end else if (c == one_char(cur_mode)) begin
        send_item(CMD_TEXT_CHAR, pick_char());
      end else begin
        if (cur_mode != MODE_LIKE_CS && $urandom_range(0, 1) == 1 &&
            ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
          c = c ^ 8'h20;
        end
        send_item(CMD_TEXT_CHAR, c);
      end
    end
    if ($urandom_range(0, 3) == 0) send_item(CMD_TEXT_CHAR, pick_char());
    send_item(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int         rand_end;
    int         quiet_from;
    int         next_phase;
    int         phase;
    int         sel;
    logic [1:0] m;
    logic [7:0] c;

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CMD_PAT_CHAR;
    char_byte_i <= 8'h00;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= MODE_LIKE_CS;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty rows, case handling, wildcard sets, byte extremes, unused mode
    set_mode(MODE_LIKE_CS);
    send_item(CMD_EVAL, 8'hFF);
    new_pattern("%%");
    eval_row("");
    eval_row("%");
    new_pattern("a%c_");
    eval_row("abbcd");
    eval_row("Abcd");
    set_mode(MODE_LIKE_CI);
    eval_row("ABCD");
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_PAT_CHAR, 8'hFF);
    send_item(CMD_PAT_CHAR, CH_PERCENT);
    send_item(CMD_TEXT_CHAR, 8'hFF);
    send_item(CMD_TEXT_CHAR, 8'h00);
    send_item(CMD_EVAL, 8'h00);
    set_mode(MODE_GLOB_CI);
    new_pattern("*?Z");
    eval_row("xyz");
    eval_row("%z");
    set_mode(MODE_SPARE);
    eval_row("Qz");

    // capacity: full pattern, then one past the row and one past the pattern
    set_mode(MODE_LIKE_CS);
    send_item(CMD_CLEAR, 8'h00);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      case ($urandom_range(0, 2))
        0:       c = "a";
        1:       c = "b";
        default: c = CH_UNDER;
      endcase
      if (i % 8 == 0) c = CH_PERCENT;
      send_item(CMD_PAT_CHAR, c);
    end
    send_derived_row();
    repeat (TEXT_MAX + 1) send_item(CMD_TEXT_CHAR, "a");
    send_item(CMD_EVAL, 8'hFF);
    send_item(CMD_PAT_CHAR, "a");
    eval_row("ab");
    send_item(CMD_EVAL, 8'h00);
    send_item(CMD_CLEAR, 8'hFF);
    send_item(CMD_EVAL, 8'h00);

    // random: mostly well-formed pattern and row sequences, some stray commands
    rand_end = items_sent + RANDOM_ITEMS;
    quiet_from = rand_end - QUIET_TAIL;
    next_phase = items_sent;
    phase = 0;
    while (items_sent < rand_end) begin
      if (items_sent >= quiet_from) idle_on = 1'b0;
      if (idle_on && items_sent >= next_phase) begin
        m = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
        set_mode(m);
        gap_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 50);
        stall_pct = (phase % 3 == 2) ? 0 : $urandom_range(20, 70);
        next_phase = items_sent + $urandom_range(30, 50);
        phase++;
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        send_random_pattern(($urandom_range(0, 29) == 0) ? $urandom_range(60, 68)
                                                          : $urandom_range(0, 8));
      end else if (sel < 45) begin
        send_random_row($urandom_range(0, 14));
      end else if (sel < 88) begin
        send_derived_row();
      end else if (sel < 97) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (idle_on) begin
        wait_all_results();
      end else begin
        send_derived_row();
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d input transfers across all four mode settings", items_sent);
    $display("and %0d verdicts: %0d matches, %0d overflowed rows", results, hits, flagged);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wpm_pkg.sv
src/wpm_ram.sv
src/wpm_dp.sv
src/wpm_ctrl.sv
src/wildcard_pattern_matcher_unit.sv
bench/match_checker.sv
bench/tb_top.sv
